// ===== rtl/hsv2rgb_pkg.sv =====
`default_nettype none
package hsv2rgb_pkg;

	localparam int HUE_W = 16;
	localparam int WEIGHT_W = 13;

	localparam logic [HUE_W-1:0] HUE_TURN = 16'd46080;
	localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd7680;
	localparam logic [HUE_W-1:0] HUE_B2 = 16'd15360;
	localparam logic [HUE_W-1:0] HUE_B3 = 16'd23040;
	localparam logic [HUE_W-1:0] HUE_B4 = 16'd30720;
	localparam logic [HUE_W-1:0] HUE_B5 = 16'd38400;
	localparam logic [WEIGHT_W-1:0] SECTOR_SPAN = 13'd7680;

	// 7680 = 15 << 9, so rounding divide is a shift then divide by 15
	localparam int SPAN_SHIFT = 9;
	localparam int SPAN_ODD = 15;
	localparam int SPAN_HALF = 3840;

	typedef enum logic [2:0] {
		SECT_R_Y,
		SECT_Y_G,
		SECT_G_C,
		SECT_C_B,
		SECT_B_M,
		SECT_M_R
	} sector_t;

endpackage
`default_nettype wire

// ===== rtl/hsv2rgb_prep.sv =====
`default_nettype none
module hsv2rgb_prep #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	output logic                               in_rdy,
	input  wire logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  wire logic [FRAC_BITS:0]            saturation,
	input  wire logic [FRAC_BITS:0]            value,
	input  wire logic [FRAC_BITS:0]            alpha_in,
	output logic                               out_vld,
	input  wire logic                          out_rdy,
	output logic [FRAC_BITS:0]                 chroma,
	output logic [FRAC_BITS:0]                 offset,
	output logic [hsv2rgb_pkg::WEIGHT_W-1:0]   weight,
	output hsv2rgb_pkg::sector_t               sector,
	output logic [FRAC_BITS:0]                 alpha
);
	import hsv2rgb_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam logic [2*W-1:0] HALF = (2*W)'(1) << (FRAC_BITS - 1);

	logic            vld_s1, vld_s2, vld_s3;
	logic            rdy1, rdy2, rdy3;
	logic [HUE_W-1:0] hue_s1;
	logic [W-1:0]    sat_s1, val_s1, alpha_s1;
	sector_t         sect_s2, sect_s3;
	logic [WEIGHT_W-1:0] weight_s2, weight_s3;
	logic [2*W-1:0]  prod_s2;
	logic [W-1:0]    val_s2, alpha_s2;
	logic [W-1:0]    c_s3, m_s3, alpha_s3;

	sector_t         sect_d;
	logic [HUE_W-1:0] pos_d;
	logic [WEIGHT_W-1:0] pos_n;
	logic [2*W-1:0]  round_d;
	logic [W-1:0]    c_d;

	assign rdy3 = !vld_s3 || out_rdy;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign in_rdy = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_vld;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	// hue wrap and clamp to 1.0
	always_ff @(posedge clk) begin
		if (rdy1) begin
			hue_s1 <= (hue >= HUE_TURN) ? hue - HUE_TURN : hue;
			sat_s1 <= (saturation > ONE) ? ONE : saturation;
			val_s1 <= (value > ONE) ? ONE : value;
			alpha_s1 <= alpha_in;
		end
	end

	always_comb begin
		if (hue_s1 >= HUE_B5) begin
			sect_d = SECT_M_R;
			pos_d = hue_s1 - HUE_B5;
		end else if (hue_s1 >= HUE_B4) begin
			sect_d = SECT_B_M;
			pos_d = hue_s1 - HUE_B4;
		end else if (hue_s1 >= HUE_B3) begin
			sect_d = SECT_C_B;
			pos_d = hue_s1 - HUE_B3;
		end else if (hue_s1 >= HUE_B2) begin
			sect_d = SECT_G_C;
			pos_d = hue_s1 - HUE_B2;
		end else if (hue_s1 >= HUE_SECTOR) begin
			sect_d = SECT_Y_G;
			pos_d = hue_s1 - HUE_SECTOR;
		end else begin
			sect_d = SECT_R_Y;
			pos_d = hue_s1;
		end
		pos_n = pos_d[WEIGHT_W-1:0];
	end

	// sector and weight, chroma product
	always_ff @(posedge clk) begin
		if (rdy2) begin
			sect_s2 <= sect_d;
			weight_s2 <= sect_d[0] ? SECTOR_SPAN - pos_n : pos_n;
			prod_s2 <= (2*W)'(sat_s1) * (2*W)'(val_s1);
			val_s2 <= val_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	assign round_d = prod_s2 + HALF;
	assign c_d = round_d[FRAC_BITS +: W];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			c_s3 <= c_d;
			m_s3 <= val_s2 - c_d;
			sect_s3 <= sect_s2;
			weight_s3 <= weight_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	assign out_vld = vld_s3;
	assign chroma = c_s3;
	assign offset = m_s3;
	assign weight = weight_s3;
	assign sector = sect_s3;
	assign alpha = alpha_s3;

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_mix.sv =====
`default_nettype none
module hsv2rgb_mix #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_vld,
	output logic                                  in_rdy,
	input  wire logic [FRAC_BITS:0]               chroma,
	input  wire logic [FRAC_BITS:0]               offset,
	input  wire logic [hsv2rgb_pkg::WEIGHT_W-1:0] weight,
	input  wire hsv2rgb_pkg::sector_t             sector,
	input  wire logic [FRAC_BITS:0]               alpha,
	output logic                                  out_vld,
	input  wire logic                             out_rdy,
	output logic [FRAC_BITS:0]                    red,
	output logic [FRAC_BITS:0]                    green,
	output logic [FRAC_BITS:0]                    blue,
	output logic [FRAC_BITS:0]                    alpha_out
);
	import hsv2rgb_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam int P_W = W + WEIGHT_W;
	localparam int Q_W = W + 4;
	localparam int K = FRAC_BITS + 9;
	localparam int RECIP_W = K - 3;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << K) + 64'(SPAN_ODD - 1)) / 64'(SPAN_ODD));
	localparam int QM_W = Q_W + RECIP_W;

	logic              vld_s4, vld_s5, vld_s6;
	logic              rdy4, rdy5, rdy6;
	logic [P_W-1:0]    p_s4;
	logic [W-1:0]      c_s4, m_s4, alpha_s4;
	sector_t           sect_s4, sect_s5;
	logic [QM_W-1:0]   qm_s5;
	logic [W-1:0]      c_s5, m_s5, alpha_s5;
	logic [W-1:0]      red_s6, green_s6, blue_s6, alpha_s6;

	logic [P_W-1:0]    sum_d;
	logic [Q_W-1:0]    q_d;
	logic [W-1:0]      x_d, cm_d, xm_d, r_d, g_d, b_d;

	assign rdy6 = !vld_s6 || out_rdy;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign in_rdy = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy4) vld_s4 <= in_vld;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			p_s4 <= P_W'(chroma) * P_W'(weight);
			c_s4 <= chroma;
			m_s4 <= offset;
			sect_s4 <= sector;
			alpha_s4 <= alpha;
		end
	end

	// rounded divide by the sector span: shift, then reciprocal of 15
	assign sum_d = p_s4 + P_W'(SPAN_HALF);
	assign q_d = sum_d[SPAN_SHIFT +: Q_W];

	always_ff @(posedge clk) begin
		if (rdy5) begin
			qm_s5 <= QM_W'(q_d) * QM_W'(RECIP);
			c_s5 <= c_s4;
			m_s5 <= m_s4;
			sect_s5 <= sect_s4;
			alpha_s5 <= alpha_s4;
		end
	end

	assign x_d = qm_s5[K +: W];
	assign cm_d = c_s5 + m_s5;
	assign xm_d = x_d + m_s5;

	always_comb begin
		case (sect_s5)
			SECT_R_Y: begin
				r_d = cm_d; g_d = xm_d; b_d = m_s5;
			end
			SECT_Y_G: begin
				r_d = xm_d; g_d = cm_d; b_d = m_s5;
			end
			SECT_G_C: begin
				r_d = m_s5; g_d = cm_d; b_d = xm_d;
			end
			SECT_C_B: begin
				r_d = m_s5; g_d = xm_d; b_d = cm_d;
			end
			SECT_B_M: begin
				r_d = xm_d; g_d = m_s5; b_d = cm_d;
			end
			default: begin
				r_d = cm_d; g_d = m_s5; b_d = xm_d;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy6) begin
			red_s6 <= r_d;
			green_s6 <= g_d;
			blue_s6 <= b_d;
			alpha_s6 <= alpha_s5;
		end
	end

	assign out_vld = vld_s6;
	assign red = red_s6;
	assign green = green_s6;
	assign blue = blue_s6;
	assign alpha_out = alpha_s6;

endmodule
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_core.sv =====
`default_nettype none
// channel   dir   tdata fields, low bit up
// s_*       in    hue, saturation, value, alpha_in
// m_*       out   red, green, blue, alpha_out
//
// six register stages, one word accepted per cycle unless the output stalls
// the two multiplies and the reciprocal divide by the sector span set the depth
// arst_n clears only the stage valid bits
// each stage holds when full and the next stage is blocked, bubbles fill in
module hsv_to_rgb_converter_core #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// hue, saturation, value, alpha_in, zero pad
	input  wire logic [((hsv2rgb_pkg::HUE_W + 3*(FRAC_BITS+1) + 7) / 8) * 8 - 1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// red, green, blue, alpha_out, zero pad
	output logic [((4*(FRAC_BITS+1) + 7) / 8) * 8 - 1:0] m_tdata
);
	import hsv2rgb_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam int OUT_W = ((4*W + 7) / 8) * 8;

	logic            mid_vld, mid_rdy;
	logic [W-1:0]    mid_c, mid_m, mid_alpha;
	logic [WEIGHT_W-1:0] mid_weight;
	sector_t         mid_sect;
	logic [W-1:0]    red, green, blue, alpha_out;

	hsv2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (s_tvalid),
		.in_rdy     (s_tready),
		.hue        (s_tdata[HUE_W-1:0]),
		.saturation (s_tdata[HUE_W +: W]),
		.value      (s_tdata[HUE_W+W +: W]),
		.alpha_in   (s_tdata[HUE_W+2*W +: W]),
		.out_vld    (mid_vld),
		.out_rdy    (mid_rdy),
		.chroma     (mid_c),
		.offset     (mid_m),
		.weight     (mid_weight),
		.sector     (mid_sect),
		.alpha      (mid_alpha)
	);

	hsv2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (mid_vld),
		.in_rdy    (mid_rdy),
		.chroma    (mid_c),
		.offset    (mid_m),
		.weight    (mid_weight),
		.sector    (mid_sect),
		.alpha     (mid_alpha),
		.out_vld   (m_tvalid),
		.out_rdy   (m_tready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha_out (alpha_out)
	);

	assign m_tdata = OUT_W'({alpha_out, blue, green, red});

endmodule
`default_nettype wire
